>>> src/bdq_pkg.sv
`default_nettype none
package bdq_pkg;

  // Fixed field widths of the channels.
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_DEPTH      = 128;
  localparam int DEF_DATA_WIDTH = 32;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // perform the ring access and update the pointers
  } bdq_cmd_t;

endpackage
`default_nettype wire

>>> src/bdq_in_if.sv
`default_nettype none
interface bdq_in_if;
  import bdq_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);

endinterface
`default_nettype wire

>>> src/bdq_out_if.sv
`default_nettype none
interface bdq_out_if;
  import bdq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] pop_value;
  logic [STATUS_W-1:0]       status;
  logic [FILL_W-1:0]         fill_count;

  modport source (output valid, output pop_value, output status, output fill_count,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input fill_count,
                  output ready);

endinterface
`default_nettype wire

>>> src/bdq_ctrl.sv
`default_nettype none
module bdq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bdq_pkg::bdq_cmd_t      cmd
);
  import bdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Sequence: take an item, run it against the ring, then hold the result.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Handshake and datapath commands follow directly from the state.
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd       = bdq_cmd_t'{load: (state_r == S_IDLE) && in_valid,
                                 exec: (state_r == S_EXEC)};

endmodule
`default_nettype wire

>>> src/bdq_dpath.sv
`default_nettype none
module bdq_dpath #(
  parameter int DEPTH      = bdq_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = bdq_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire bdq_pkg::bdq_cmd_t                   cmd,
  input  wire logic [bdq_pkg::KIND_W-1:0]          in_kind,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0]  in_push_value,
  output logic signed [bdq_pkg::VALUE_W-1:0]       out_pop_value,
  output logic [bdq_pkg::STATUS_W-1:0]             out_status,
  output logic [bdq_pkg::FILL_W-1:0]               out_fill_count
);
  import bdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT   = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX   = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_WIDE = (AW+1)'(DEPTH);

  // Ring storage.
  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]         head_r;
  logic [AW-1:0]         head_nxt;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [KIND_W-1:0]     kind_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  pop_ok_r;
  logic [STATUS_W-1:0]   status_r;
  logic [FILL_W-1:0]     fill_r;

  logic                  is_push;
  logic                  is_full;
  logic                  is_empty;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         head_inc;
  logic [AW-1:0]         back_off;
  logic [AW:0]           back_sum;
  logic [AW-1:0]         back_pos;
  logic [AW-1:0]         addr;
  logic                  wr_en;
  logic                  pop_ok;
  logic [STATUS_W-1:0]   status_nxt;
  logic [63:0]           push_ext;
  logic [63:0]           pop_ext;
  logic [31:0]           count_ext;

  // Incoming item, kept to the stored word width.
  assign push_ext = 64'($unsigned(in_push_value));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      word_r <= push_ext[DATA_WIDTH-1:0];
    end
  end

  // Ring position arithmetic, with an explicit wrap for any depth.
  assign is_push  = (kind_r == KIND_PUSH_FRONT) || (kind_r == KIND_PUSH_BACK);
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - AW'(1);
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
  assign back_off = (kind_r == KIND_PUSH_BACK) ? count_r[AW-1:0]
                                               : count_r[AW-1:0] - AW'(1);
  assign back_sum = {1'b0, head_r} + {1'b0, back_off};
  assign back_pos = (back_sum >= DEPTH_WIDE) ? AW'(back_sum - DEPTH_WIDE)
                                             : back_sum[AW-1:0];

  // Decide the effect of the operation on pointers and status.
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    addr       = head_r;
    wr_en      = 1'b0;
    pop_ok     = 1'b0;
    status_nxt = ST_OK;
    unique case (kind_r)
      KIND_PUSH_FRONT: begin
        addr = head_dec;
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_PUSH_BACK: begin
        addr = back_pos;
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_POP_FRONT: begin
        addr = head_r;
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      KIND_POP_BACK: begin
        addr = back_pos;
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Memory port: one write or one registered read per operation.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) begin
        mem[addr] <= word_r;
      end
      rdata_r <= mem[addr];
    end
  end

  // Ring pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Result register, held until the item is taken.
  assign count_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pop_ok_r <= pop_ok && !is_push;
      status_r <= status_nxt;
      fill_r   <= count_ext[FILL_W-1:0];
    end
  end

  assign pop_ext        = 64'(rdata_r);
  assign out_pop_value  = pop_ok_r ? $signed(pop_ext[VALUE_W-1:0]) : '0;
  assign out_status     = status_r;
  assign out_fill_count = fill_r;

endmodule
`default_nettype wire

>>> src/bounded_double_ended_queue.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// in_chan   input      valid / ready      kind, push_value
// out_chan  output     valid / ready      pop_value, status, fill_count
//
// An item is captured at its accepting edge, the single ring memory access
// and pointer update take the following cycle, and the result is valid from
// the next edge until it is taken. in_chan.ready is high only while no item
// is in progress, so a new item is accepted only after the last result is
// taken, and a waiting result holds the input off. Reset is synchronous and
// active low; it empties the queue and the ring contents are left as they
// are.
module bounded_double_ended_queue #(
  parameter int DEPTH      = bdq_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = bdq_pkg::DEF_DATA_WIDTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bdq_in_if.sink     in_chan,
  bdq_out_if.source  out_chan
);
  import bdq_pkg::*;

  bdq_cmd_t cmd;

  // Sequencer.
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // Ring storage and pointers.
  bdq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_chan.kind),
    .in_push_value  (in_chan.push_value),
    .out_pop_value  (out_chan.pop_value),
    .out_status     (out_chan.status),
    .out_fill_count (out_chan.fill_count)
  );

endmodule
`default_nettype wire
